// File: hdl/n2dd_pkg.sv
package n2dd_pkg;

  // Display and field geometry.
  localparam int MAX_CELLS     = 16;
  localparam int VALUE_W       = 32;
  localparam int CNT_W         = 5;
  localparam int COL_W         = 5;
  localparam int LINE_W        = 3;
  localparam int CHAR_W        = 7;
  localparam int CMD_W         = 2;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 16;

  // Cell index and running column widths.
  localparam int IDX_W         = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int POS_COL_W     = $clog2((1 << COL_W) + MAX_CELLS);

  // Binary to BCD conversion: ten decimal digits cover 32 bits.
  localparam int BCD_DIGITS    = 10;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int HEX_DIGITS    = VALUE_W / 4;
  localparam int BITS_PER_CELL = 2;
  localparam int NUM_CELLS     = VALUE_W / BITS_PER_CELL;

  // Text position limits.
  localparam int LINE_MIN      = 1;
  localparam int LINE_MAX      = 4;
  localparam int COL_MIN       = 1;
  localparam int COL_MAX       = 16;

  // Number formats.
  localparam logic [CMD_W-1:0] CMD_UDEC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HEX  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BIN  = 2'd3;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'd55;  // 'A' minus ten

  // One request as it travels down the conversion chain.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               neg;
    logic [CNT_W-1:0]   count;
    logic [COL_W-1:0]   col;
    logic [LINE_W-1:0]  line;
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } conv_t;

endpackage

// File: hdl/n2dd_cell.sv
module n2dd_cell import n2dd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  conv_t in_data,
  output logic  out_valid,
  output conv_t out_data
);

  conv_t stepped;

  // Two shift-and-add-3 steps. The binary word rotates, so after the whole
  // chain it holds the magnitude again next to its BCD form.
  always_comb begin
    stepped = in_data;
    for (int s = 0; s < BITS_PER_CELL; s++) begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        if (stepped.bcd[4*i +: 4] >= 4'd5) begin
          stepped.bcd[4*i +: 4] = stepped.bcd[4*i +: 4] + 4'd3;
        end
      end
      stepped.bcd = {stepped.bcd[BCD_W-2:0], stepped.bin[VALUE_W-1]};
      stepped.bin = {stepped.bin[VALUE_W-2:0], stepped.bin[VALUE_W-1]};
    end
  end

  // Stage register; the whole chain moves together when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= stepped;
    end
  end

endmodule

// File: hdl/n2dd_serializer.sv
module n2dd_serializer import n2dd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  conv_t                 in_data,
  output logic                  ready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // char_code, out_line, out_column
  output logic                  m_axis_tlast   // last
);

  logic                 busy;
  logic                 sign_pend;
  logic                 has_digits;
  logic                 started;
  logic [IDX_W-1:0]     idx;
  logic [POS_COL_W-1:0] col;
  logic [CMD_W-1:0]     mode;
  logic [LINE_W-1:0]    line;
  logic [VALUE_W-1:0]   bin;
  logic [BCD_W-1:0]     bcd;

  logic [CHAR_W-1:0]    out_char;
  logic [LINE_W-1:0]    out_line;
  logic [COL_W-1:0]     out_col;

  logic                 out_free;
  logic                 fire;
  logic                 fin;
  logic                 load;
  logic [3:0]           digit;
  logic                 blank;
  logic                 emit_last;
  logic [CHAR_W-1:0]    ch;
  logic [COL_W-1:0]     col_clamped;
  logic [CNT_W-1:0]     cells_m1;

  // Pick the digit for the current cell, most significant first.
  always_comb begin
    digit = 4'd0;
    case (mode)
      CMD_UDEC, CMD_SDEC: begin
        if (int'(idx) < BCD_DIGITS) begin
          digit = bcd[4*int'(idx) +: 4];
        end
      end
      CMD_HEX: begin
        if (int'(idx) < HEX_DIGITS) begin
          digit = bin[4*int'(idx) +: 4];
        end
      end
      CMD_BIN: begin
        if (int'(idx) < VALUE_W) begin
          digit = {3'b000, bin[idx]};
        end
      end
      default: digit = 4'd0;
    endcase
  end

  // Leading zeros become spaces, except in binary and on the final cell.
  assign blank = (mode != CMD_BIN) && !started && (digit == 4'd0) && (idx != '0);

  always_comb begin
    if (sign_pend) begin
      ch = CH_MINUS;
    end else if (blank) begin
      ch = CH_SPACE;
    end else if (digit < 4'd10) begin
      ch = CH_ZERO + CHAR_W'(digit);
    end else begin
      ch = CH_ALPHA + CHAR_W'(digit);
    end
  end

  // Column clamp to the display width.
  always_comb begin
    if (col < POS_COL_W'(COL_MIN)) begin
      col_clamped = COL_W'(COL_MIN);
    end else if (col > POS_COL_W'(COL_MAX)) begin
      col_clamped = COL_W'(COL_MAX);
    end else begin
      col_clamped = col[COL_W-1:0];
    end
  end

  assign emit_last = sign_pend ? !has_digits : (idx == '0);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign fire      = busy && out_free;
  assign fin       = fire && emit_last;
  assign ready     = !busy || fin;
  assign load      = in_valid && ready;
  assign cells_m1  = in_data.count - CNT_W'(1) - CNT_W'(in_data.neg);

  // Cell sequencer: one character per cycle while the output has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= (in_data.count != '0);
    end else if (fin) begin
      busy <= 1'b0;
    end
  end

  // A new request replaces the one whose final character goes out now.
  always_ff @(posedge clk) begin
    if (load) begin
      sign_pend  <= in_data.neg;
      has_digits <= !(in_data.neg && (in_data.count == CNT_W'(1)));
      started    <= 1'b0;
      idx        <= cells_m1[IDX_W-1:0];
      col        <= POS_COL_W'(in_data.col);
      mode       <= in_data.cmd;
      line       <= in_data.line;
      bin        <= in_data.bin;
      bcd        <= in_data.bcd;
    end else if (fire) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - IDX_W'(1);
        if (!blank) begin
          started <= 1'b1;
        end
      end
      col <= col + POS_COL_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char     <= ch;
      out_line     <= line;
      out_col      <= col_clamped;
      m_axis_tlast <= emit_last;
    end
  end

  assign m_axis_tdata = {1'b0, out_col, out_line, out_char};

endmodule

// File: hdl/number_to_display_digits_core.sv
// An accepted request passes every cell register of the chain and the serializer before its first character is offered.
// Throughput is set by the serializer, which emits one character per cycle while the output has room
// and takes the next request as the final character of the one before goes out.
// The 16-cell conversion chain takes a new request in every cycle it moves.
// Reset (synchronous) empties the chain, the serializer and the output.
module number_to_display_digits_core import n2dd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // value, digit_count, start_column, text_line
  input  logic [CMD_W-1:0]      s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // char_code, out_line, out_column
  output logic                  m_axis_tlast   // last
);

  logic               chain_valid [0:NUM_CELLS];
  conv_t              chain_data  [0:NUM_CELLS];
  logic               advance;
  logic               ser_ready;
  logic [VALUE_W-1:0] value;
  logic [CNT_W-1:0]   digit_count;
  logic [COL_W-1:0]   start_column;
  logic [LINE_W-1:0]  text_line;
  conv_t              entry;

  assign value        = s_axis_tdata[VALUE_W-1:0];
  assign digit_count  = s_axis_tdata[VALUE_W +: CNT_W];
  assign start_column = s_axis_tdata[VALUE_W + CNT_W +: COL_W];
  assign text_line    = s_axis_tdata[VALUE_W + CNT_W + COL_W +: LINE_W];

  // Request entry: clamp count and line, take the magnitude of negatives.
  always_comb begin
    entry.cmd = s_axis_tuser;
    entry.neg = (s_axis_tuser == CMD_SDEC) && value[VALUE_W-1];
    entry.bin = entry.neg ? (~value + VALUE_W'(1)) : value;
    entry.bcd = '0;
    entry.col = start_column;
    if (int'(digit_count) > MAX_CELLS) begin
      entry.count = CNT_W'(MAX_CELLS);
    end else begin
      entry.count = digit_count;
    end
    if (text_line < LINE_W'(LINE_MIN)) begin
      entry.line = LINE_W'(LINE_MIN);
    end else if (text_line > LINE_W'(LINE_MAX)) begin
      entry.line = LINE_W'(LINE_MAX);
    end else begin
      entry.line = text_line;
    end
  end

  assign chain_valid[0] = s_axis_tvalid;
  assign chain_data[0]  = entry;

  // The chain stalls only when its last cell holds a request the
  // serializer cannot take yet.
  assign advance       = !chain_valid[NUM_CELLS] || ser_ready;
  assign s_axis_tready = advance;

  // Conversion chain.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    n2dd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  // Character serializer and output register.
  n2dd_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chain_valid[NUM_CELLS]),
    .in_data       (chain_data[NUM_CELLS]),
    .ready         (ser_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/n2dd_checker.sv
module n2dd_checker import n2dd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Every character is a space, a minus, a digit or a hex letter range code.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6:0] >= CH_SPACE) &&
                      (m_axis_tdata[6:0] <= CH_ALPHA + 7'd15))
    else $error("character code out of range");

  // Line and column always lie on the display.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:7] >= 3'd1) && (m_axis_tdata[9:7] <= 3'd4) &&
                      (m_axis_tdata[14:10] >= 5'd1) && (m_axis_tdata[14:10] <= 5'd16))
    else $error("text position off the display");

  // Reset leaves no result offered and an empty block ready for requests.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty right after reset");

endmodule

bind number_to_display_digits_core n2dd_checker u_n2dd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
